// ===== src/rpcd_pkg.sv =====
package rpcd_pkg;

  localparam int BYTE_W      = 8;
  localparam int FRAME_W     = 14;
  localparam int CNT_W       = 4;
  localparam int MAX_COPIES  = 8;
  localparam int RESULT_CAP  = 32;
  localparam int N_W         = $clog2(RESULT_CAP + 1);
  localparam int FRAME_MIN   = 1;
  localparam int FRAME_MAX   = 8192;
  localparam int FRAME_RESET = 512;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ONE   = 2'd1,
    PH_PAIR  = 2'd2
  } phase_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // One classified input item: a first emission (literal or run), an
  // optional trailing literal, and the end-of-stream mark.
  typedef struct packed {
    logic [BYTE_W-1:0] a_val;
    logic [BYTE_W-1:0] a_cnt;
    logic              b_valid;
    logic [BYTE_W-1:0] b_val;
    logic              eos;
  } cmd_t;

endpackage

// ===== src/rpcd_front.sv =====
module rpcd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rpcd_pkg::BYTE_W-1:0] code_byte,
  input  logic                      end_of_stream,
  input  logic                      q_full,
  output logic                      push,
  output rpcd_pkg::cmd_t            push_cmd
);
  import rpcd_pkg::*;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] pend, pend_next;
  logic              take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_EMPTY;
      pend  <= '0;
    end else begin
      phase <= phase_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    pend_next        = pend;
    push             = 1'b0;
    push_cmd.a_val   = pend;
    push_cmd.a_cnt   = BYTE_W'(1);
    push_cmd.b_valid = 1'b0;
    push_cmd.b_val   = code_byte;
    push_cmd.eos     = end_of_stream;
    if (take) begin
      unique case (phase)
        PH_ONE: begin
          if (code_byte == pend && !end_of_stream) begin
            phase_next = PH_PAIR;
          end else begin
            push = 1'b1;
            if (end_of_stream) begin
              push_cmd.b_valid = 1'b1;
              phase_next       = PH_EMPTY;
            end else begin
              pend_next  = code_byte;
              phase_next = PH_ONE;
            end
          end
        end
        PH_PAIR: begin
          push           = 1'b1;
          push_cmd.a_cnt = code_byte;
          phase_next     = PH_EMPTY;
        end
        default: begin
          if (end_of_stream) begin
            push           = 1'b1;
            push_cmd.a_val = code_byte;
            phase_next     = PH_EMPTY;
          end else begin
            pend_next  = code_byte;
            phase_next = PH_ONE;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/rpcd_queue.sv =====
module rpcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpcd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output rpcd_pkg::cmd_t pop_cmd,
  output logic           not_empty
);
  import rpcd_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push, do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rpcd_back.sv =====
module rpcd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rpcd_pkg::FRAME_W-1:0] cfg_wr_data,
  input  logic                        q_valid,
  input  rpcd_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rpcd_pkg::BYTE_W-1:0] pixel_byte,
  output logic [rpcd_pkg::CNT_W-1:0]  copies,
  output logic                        frame_last
);
  import rpcd_pkg::*;

  back_state_t        state, state_next;
  logic [FRAME_W-1:0] frame_size;
  logic [FRAME_W-1:0] lim;
  logic [BYTE_W-1:0]  cur_val, cur_val_next;
  logic [BYTE_W-1:0]  rem, rem_next;
  logic               b_pend, b_pend_next;
  logic [BYTE_W-1:0]  b_val, b_val_next;
  logic               eos_f, eos_f_next;
  logic [N_W-1:0]     n, n_next;
  logic [FRAME_W-1:0] be, be_next;
  logic               full, full_next;
  logic               out_valid_next;
  logic [BYTE_W-1:0]  pixel_byte_next;
  logic [CNT_W-1:0]   copies_next;
  logic               frame_last_next;
  logic               slot_free;
  logic [FRAME_W-1:0] room;
  logic [CNT_W-1:0]   c0, c;
  logic               reached, more;

  // Clamp the programmed size into the legal frame range.
  always_comb begin
    if (frame_size < FRAME_W'(FRAME_MIN)) begin
      lim = FRAME_W'(FRAME_MIN);
    end else if (frame_size > FRAME_W'(FRAME_MAX)) begin
      lim = FRAME_W'(FRAME_MAX);
    end else begin
      lim = frame_size;
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign room      = lim - be;
  assign c0        = (rem > BYTE_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : rem[CNT_W-1:0];
  assign c         = (room < FRAME_W'(c0)) ? room[CNT_W-1:0] : c0;
  assign reached   = ((be + FRAME_W'(c)) >= lim);
  assign more      = ((rem != BYTE_W'(c)) && (n < N_W'(RESULT_CAP - 1))) || b_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= FRAME_W'(FRAME_RESET);
      state      <= BK_IDLE;
      be         <= '0;
      full       <= 1'b0;
      out_valid  <= 1'b0;
      b_pend     <= 1'b0;
      eos_f      <= 1'b0;
      n          <= '0;
      rem        <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_size <= cfg_wr_data;
      end
      state     <= state_next;
      be        <= be_next;
      full      <= full_next;
      out_valid <= out_valid_next;
      b_pend    <= b_pend_next;
      eos_f     <= eos_f_next;
      n         <= n_next;
      rem       <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_val    <= cur_val_next;
    b_val      <= b_val_next;
    pixel_byte <= pixel_byte_next;
    copies     <= copies_next;
    frame_last <= frame_last_next;
  end

  always_comb begin
    state_next      = state;
    cur_val_next    = cur_val;
    rem_next        = rem;
    b_pend_next     = b_pend;
    b_val_next      = b_val;
    eos_f_next      = eos_f;
    n_next          = n;
    be_next         = be;
    full_next       = full;
    q_pop           = 1'b0;
    out_valid_next  = out_valid && out_stall;
    pixel_byte_next = pixel_byte;
    copies_next     = copies;
    frame_last_next = frame_last;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          cur_val_next = q_cmd.a_val;
          rem_next     = q_cmd.a_cnt;
          b_pend_next  = q_cmd.b_valid;
          b_val_next   = q_cmd.b_val;
          eos_f_next   = q_cmd.eos;
          n_next       = '0;
          state_next   = BK_RUN;
        end
      end
      BK_RUN: begin
        if (slot_free) begin
          if (rem != '0 && !full && n < N_W'(RESULT_CAP)) begin
            out_valid_next = 1'b1;
            n_next         = n + 1'b1;
            if (be >= lim) begin
              // Limit already met (lowered since the frame began): end marker.
              pixel_byte_next = '0;
              copies_next     = '0;
              frame_last_next = 1'b1;
              full_next       = 1'b1;
              rem_next        = '0;
            end else begin
              pixel_byte_next = cur_val;
              copies_next     = c;
              frame_last_next = reached || (eos_f && !more);
              full_next       = reached;
              be_next         = be + FRAME_W'(c);
              rem_next        = rem - BYTE_W'(c);
            end
          end else if (b_pend && !full) begin
            cur_val_next = b_val;
            rem_next     = BYTE_W'(1);
            b_pend_next  = 1'b0;
          end else begin
            if (eos_f && !full && n == '0) begin
              out_valid_next  = 1'b1;
              pixel_byte_next = '0;
              copies_next     = '0;
              frame_last_next = 1'b1;
            end
            if (eos_f) begin
              be_next   = '0;
              full_next = 1'b0;
            end
            rem_next    = '0;
            b_pend_next = 1'b0;
            state_next  = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rle_pair_count_decoder.sv =====
// Run-length decoder for display frames. Each input transaction carries one
// code byte and an end-of-stream flag; a byte followed by an equal byte opens
// a run whose length (0 to 255) is the next byte, any other byte is a
// literal. Output transactions carry a byte value and a copy count of 1 to
// MAX_COPIES (8); copies of 0 is an end marker. Output stops once frame_size
// bytes (clamped to 1..8192, reset 512) have gone out: that transaction has
// frame_last set and input is dropped until end_of_stream, which also closes
// every frame with frame_last on its final transaction. Timing: the front end
// takes one input per cycle while its two-entry command queue has room;
// bytes that only complete a pair, or wait to be classified, push nothing.
// Every other input becomes one command; the back end pops it, sends its
// output transactions (a run of N gives ceil(N/8) of them), switches to a
// trailing literal, and closes it, and it takes a new command only once
// it has closed the last. Apart from the pop, the back end advances only
// while the output register is free or being taken. Write frame_size only
// while the block is idle.
module rle_pair_count_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rpcd_pkg::FRAME_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpcd_pkg::BYTE_W-1:0]   code_byte,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpcd_pkg::BYTE_W-1:0]   pixel_byte,
  output logic [rpcd_pkg::CNT_W-1:0]    copies,
  output logic                          frame_last
);
  import rpcd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Front end: pair detection, hold the pending byte, push commands.
  rpcd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_byte     (code_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  // Decouple classification from expansion.
  rpcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  // Back end: split runs, track the frame count, mark the end of frame.
  rpcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_byte  (pixel_byte),
    .copies      (copies),
    .frame_last  (frame_last)
  );

endmodule

// ===== src/rpcd_checker.sv =====
module rpcd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rpcd_pkg::BYTE_W-1:0]  pixel_byte,
  input logic [rpcd_pkg::CNT_W-1:0]   copies,
  input logic                         frame_last
);
  import rpcd_pkg::*;

  // No transaction may carry more copies than one result holds.
  a_copies_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (copies <= CNT_W'(MAX_COPIES)))
    else $error("copies above MAX_COPIES");

  // An empty transaction is only ever an end marker.
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && copies == '0) |-> (frame_last && pixel_byte == '0))
    else $error("zero copies without end marker form");

  // A stalled transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(pixel_byte) && $stable(copies) && $stable(frame_last)))
    else $error("stalled output changed");

  // Nothing is offered right out of reset.
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind rle_pair_count_decoder rpcd_checker u_rpcd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_byte (pixel_byte),
  .copies     (copies),
  .frame_last (frame_last)
);
